FILE: hdl/ahmc_pkg.sv
// Shared types, codes and reset constants for the headlight mode controller.
`default_nettype none

package ahmc_pkg;

  localparam int unsigned TimerBitsDef = 16;
  localparam int unsigned ThrW         = 16;
  localparam int unsigned LuxW         = 16;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned InDataW      = 24;
  localparam int unsigned OutDataW     = 8;

  localparam logic [ThrW-1:0] OnThrRst   = 16'd60;
  localparam logic [ThrW-1:0] OffThrRst  = 16'd70;
  localparam logic [ThrW-1:0] OffDlyRst  = 16'd300;
  localparam logic [ThrW-1:0] OnDlyRst   = 16'd200;
  localparam logic            DarkLitRst = 1'b0;

  typedef enum logic [1:0] {
    SW_OFF  = 2'd0,
    SW_ON   = 2'd1,
    SW_AUTO = 2'd2,
    SW_ANY  = 2'd3
  } switch_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_AUTO = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    PH_NONE   = 3'd0,
    PH_ENTER  = 3'd1,
    PH_OFF    = 3'd2,
    PH_LIT    = 3'd3,
    PH_TO_OFF = 3'd4,
    PH_TO_ON  = 3'd5
  } phase_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_ON_THR   = 3'd0,
    CFG_OFF_THR  = 3'd1,
    CFG_OFF_DLY  = 3'd2,
    CFG_ON_DLY   = 3'd3,
    CFG_DARK_LIT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0] on_thr;
    logic [ThrW-1:0] off_thr;
    logic [ThrW-1:0] off_dly;
    logic [ThrW-1:0] on_dly;
    logic            dark_lit;
  } cfg_t;

  // headlight in the lowest bit
  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] mode;
    logic       headlight;
  } result_t;

  localparam int unsigned ResW = $bits(result_t);

  typedef struct packed {
    logic full;
    logic empty;
  } buf_status_t;

endpackage

`default_nettype wire

FILE: hdl/auto_headlight_mode_controller.sv
// Automatic headlight mode controller: switch/light samples in, drive and mode out.
//
// Input stream (s_axis): one transfer per control tick, carrying the switch
// position and the ambient light reading. Each accepted transfer produces
// exactly one output transfer (m_axis) with the headlight drive, the mode and
// the auto phase after that tick's update.
// The result is written into the result buffer on the input transfer.
// Throughput: one tick per cycle while the buffer has room; the state update is
// a single pass of compares and a saturating counter between the state registers.
// A two-entry result buffer lets the next tick be taken while a result still
// waits; s_axis_tready drops only when both entries are held by a stalled
// receiver, and rises again as soon as one result is taken.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 on threshold, 1 off threshold, 2 off delay, 3 on delay, 4 dark
// entry lit). Write only while no tick is outstanding.
// Reset (rst_ni low, async): registers take their default values, the
// controller returns to its not-started state and the buffer empties.
// The first tick after reset only enters off mode.
`default_nettype none

module auto_headlight_mode_controller #(
  parameter int unsigned TimerBits = ahmc_pkg::TimerBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // [1:0] switch_pos, [17:2] intensity, [23:18] zero
  input  wire logic [ahmc_pkg::InDataW-1:0]      s_axis_tdata,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] headlight, [2:1] mode_now, [5:3] phase_now, [7:6] zero
  output      logic [ahmc_pkg::OutDataW-1:0]     m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [ahmc_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  wire logic [ahmc_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  ahmc_pkg::cfg_t        cfg;
  ahmc_pkg::result_t     result;
  ahmc_pkg::result_t     head;
  ahmc_pkg::buf_status_t buf_status;
  logic                  in_xfer;
  logic                  out_xfer;

  assign s_axis_tready = !buf_status.full;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = !buf_status.empty;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  ahmc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ahmc_ctrl #(
    .TimerBits (TimerBits)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_xfer),
    .switch_pos_i (s_axis_tdata[1:0]),
    .intensity_i  (s_axis_tdata[17:2]),
    .cfg_i        (cfg),
    .result_o     (result)
  );

  ahmc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .push_data_i (result),
    .pop_i       (out_xfer),
    .head_o      (head),
    .status_o    (buf_status)
  );

  assign m_axis_tdata = {{(ahmc_pkg::OutDataW - ahmc_pkg::ResW){1'b0}}, head};

  a_xfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> m_axis_tvalid)
    else $error("input transfer not followed by a pending result");

  a_phase_only_in_auto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && head.mode != ahmc_pkg::MODE_AUTO) |-> head.phase == ahmc_pkg::PH_NONE)
    else $error("auto phase active outside auto mode");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((head.mode == ahmc_pkg::MODE_OFF || head.mode == ahmc_pkg::MODE_ON ||
                        head.mode == ahmc_pkg::MODE_AUTO) && head.phase <= ahmc_pkg::PH_TO_ON))
    else $error("illegal mode or phase code in result");

endmodule

`default_nettype wire

FILE: hdl/ahmc_cfg.sv
// Configuration register file: thresholds, hold delays and dark entry select.
`default_nettype none

module ahmc_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ahmc_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [ahmc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output ahmc_pkg::cfg_t                        cfg_o
);

  ahmc_pkg::cfg_t cfg_q;
  ahmc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ahmc_pkg::cfg_idx_e'(cfg_addr_i))
        ahmc_pkg::CFG_ON_THR:   cfg_d.on_thr   = cfg_wdata_i;
        ahmc_pkg::CFG_OFF_THR:  cfg_d.off_thr  = cfg_wdata_i;
        ahmc_pkg::CFG_OFF_DLY:  cfg_d.off_dly  = cfg_wdata_i;
        ahmc_pkg::CFG_ON_DLY:   cfg_d.on_dly   = cfg_wdata_i;
        ahmc_pkg::CFG_DARK_LIT: cfg_d.dark_lit = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_thr   <= ahmc_pkg::OnThrRst;
      cfg_q.off_thr  <= ahmc_pkg::OffThrRst;
      cfg_q.off_dly  <= ahmc_pkg::OffDlyRst;
      cfg_q.on_dly   <= ahmc_pkg::OnDlyRst;
      cfg_q.dark_lit <= ahmc_pkg::DarkLitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/ahmc_ctrl.sv
// Mode, auto phase, hold timer and drive state with their per-tick update.
`default_nettype none

module ahmc_ctrl #(
  parameter int unsigned TimerBits = ahmc_pkg::TimerBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [1:0]                    switch_pos_i,
  input  wire logic [ahmc_pkg::LuxW-1:0]     intensity_i,
  input  wire ahmc_pkg::cfg_t                cfg_i,
  output ahmc_pkg::result_t                  result_o
);

  localparam int unsigned CmpW = (TimerBits > ahmc_pkg::ThrW) ? TimerBits : ahmc_pkg::ThrW;
  localparam logic [TimerBits-1:0] TimerMax = '1;

  logic                  started_q, started_d;
  ahmc_pkg::mode_e       mode_q, mode_d;
  ahmc_pkg::phase_e      phase_q, phase_d;
  logic [TimerBits-1:0]  timer_q, timer_d;
  logic                  light_q, light_d;

  logic                  lux_above_off;
  logic                  lux_below_on;
  logic                  off_hold_done;
  logic                  on_hold_done;
  logic [TimerBits-1:0]  timer_inc;
  ahmc_pkg::switch_e     sw;

  assign sw            = ahmc_pkg::switch_e'(switch_pos_i);
  assign lux_above_off = intensity_i > cfg_i.off_thr;
  assign lux_below_on  = intensity_i < cfg_i.on_thr;
  assign off_hold_done = CmpW'(timer_q) >= CmpW'(cfg_i.off_dly);
  assign on_hold_done  = CmpW'(timer_q) >= CmpW'(cfg_i.on_dly);
  assign timer_inc     = (timer_q == TimerMax) ? timer_q : timer_q + 1'b1;

  always_comb begin
    started_d = started_q;
    mode_d    = mode_q;
    phase_d   = phase_q;
    timer_d   = timer_q;
    light_d   = light_q;
    if (!started_q) begin
      started_d = 1'b1;
      mode_d    = ahmc_pkg::MODE_OFF;
    end else begin
      unique case (mode_q)
        ahmc_pkg::MODE_AUTO: begin
          if (sw == ahmc_pkg::SW_ON) begin
            phase_d = ahmc_pkg::PH_NONE;
            mode_d  = ahmc_pkg::MODE_ON;
          end else if (sw == ahmc_pkg::SW_OFF) begin
            phase_d = ahmc_pkg::PH_NONE;
            mode_d  = ahmc_pkg::MODE_OFF;
          end else begin
            case (phase_q)
              ahmc_pkg::PH_ENTER: begin
                phase_d = (!lux_above_off && cfg_i.dark_lit) ? ahmc_pkg::PH_LIT
                                                             : ahmc_pkg::PH_OFF;
              end
              ahmc_pkg::PH_OFF: begin
                if (lux_below_on) begin
                  phase_d = ahmc_pkg::PH_TO_ON;
                end else begin
                  light_d = 1'b0;
                  timer_d = '0;
                end
              end
              ahmc_pkg::PH_LIT: begin
                if (lux_above_off) begin
                  phase_d = ahmc_pkg::PH_TO_OFF;
                end else begin
                  light_d = 1'b1;
                  timer_d = '0;
                end
              end
              ahmc_pkg::PH_TO_OFF: begin
                if (!lux_above_off) begin
                  phase_d = ahmc_pkg::PH_LIT;
                end else if (off_hold_done) begin
                  phase_d = ahmc_pkg::PH_OFF;
                end else begin
                  timer_d = timer_inc;
                end
              end
              default: begin
                if (!lux_below_on) begin
                  phase_d = ahmc_pkg::PH_OFF;
                end else if (on_hold_done) begin
                  phase_d = ahmc_pkg::PH_LIT;
                end else begin
                  timer_d = timer_inc;
                  phase_d = ahmc_pkg::PH_TO_ON;
                end
              end
            endcase
          end
        end
        ahmc_pkg::MODE_OFF: begin
          if (sw == ahmc_pkg::SW_AUTO) begin
            mode_d  = ahmc_pkg::MODE_AUTO;
            phase_d = ahmc_pkg::PH_ENTER;
          end else if (sw == ahmc_pkg::SW_ON) begin
            mode_d = ahmc_pkg::MODE_ON;
          end else begin
            light_d = 1'b0;
          end
        end
        default: begin
          if (sw == ahmc_pkg::SW_OFF) begin
            mode_d = ahmc_pkg::MODE_OFF;
          end else if (sw == ahmc_pkg::SW_AUTO) begin
            mode_d  = ahmc_pkg::MODE_AUTO;
            phase_d = ahmc_pkg::PH_ENTER;
          end else begin
            light_d = 1'b1;
            mode_d  = ahmc_pkg::MODE_ON;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      mode_q    <= ahmc_pkg::MODE_OFF;
      phase_q   <= ahmc_pkg::PH_NONE;
      timer_q   <= '0;
      light_q   <= 1'b0;
    end else if (step_i) begin
      started_q <= started_d;
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      light_q   <= light_d;
    end
  end

  // result carries the state after this tick's update
  assign result_o.headlight = light_d;
  assign result_o.mode      = mode_d;
  assign result_o.phase     = phase_d;

endmodule

`default_nettype wire

FILE: hdl/ahmc_outbuf.sv
// Two-entry result buffer between the state update and the output stream.
`default_nettype none

module ahmc_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ahmc_pkg::result_t push_data_i,
  input  wire logic              pop_i,
  output ahmc_pkg::result_t      head_o,
  output ahmc_pkg::buf_status_t  status_o
);

  ahmc_pkg::result_t mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = cnt_q[1];
  assign status_o.empty = (cnt_q == 2'd0);

endmodule

`default_nettype wire

FILE: dv/ahmc_checker.sv
// Checker for the headlight mode controller: mirrors the registers, predicts and compares results.
`timescale 1ns / 1ps

module ahmc_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  // [1:0] switch_pos, [17:2] intensity, [23:18] zero
  input  logic [ahmc_pkg::InDataW-1:0]       s_axis_tdata,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] headlight, [2:1] mode_now, [5:3] phase_now, [7:6] zero
  input  logic [ahmc_pkg::OutDataW-1:0]      m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [ahmc_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [ahmc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import ahmc_pkg::*;

  cfg_t                     cfg_q;
  logic                     started_q;
  mode_e                    mode_q;
  phase_e                   phase_q;
  logic [TimerBitsDef-1:0]  hold_q;
  logic                     lamp_q;
  result_t                  lamp_results_q[$];
  int                       fails = 0;

  function automatic result_t advance_tick(switch_e sw, logic [LuxW-1:0] lux);
    result_t r;
    if (!started_q) begin
      started_q = 1'b1;
      mode_q    = MODE_OFF;
    end else if (mode_q == MODE_AUTO) begin
      if (sw == SW_ON) begin
        phase_q = PH_NONE;
        mode_q  = MODE_ON;
      end else if (sw == SW_OFF) begin
        phase_q = PH_NONE;
        mode_q  = MODE_OFF;
      end else begin
        case (phase_q)
          PH_ENTER: begin
            if (lux > cfg_q.off_thr || !cfg_q.dark_lit) phase_q = PH_OFF;
            else phase_q = PH_LIT;
          end
          PH_OFF: begin
            if (lux < cfg_q.on_thr) begin
              phase_q = PH_TO_ON;
            end else begin
              lamp_q = 1'b0;
              hold_q = '0;
            end
          end
          PH_LIT: begin
            if (lux > cfg_q.off_thr) begin
              phase_q = PH_TO_OFF;
            end else begin
              lamp_q = 1'b1;
              hold_q = '0;
            end
          end
          PH_TO_OFF: begin
            if (lux <= cfg_q.off_thr) phase_q = PH_LIT;
            else if (hold_q >= cfg_q.off_dly) phase_q = PH_OFF;
            else if (hold_q != '1) hold_q = hold_q + 1'b1;
          end
          default: begin
            if (lux >= cfg_q.on_thr) begin
              phase_q = PH_OFF;
            end else if (hold_q >= cfg_q.on_dly) begin
              phase_q = PH_LIT;
            end else begin
              if (hold_q != '1) hold_q = hold_q + 1'b1;
              phase_q = PH_TO_ON;
            end
          end
        endcase
      end
    end else if (mode_q == MODE_OFF) begin
      if (sw == SW_AUTO) begin
        mode_q  = MODE_AUTO;
        phase_q = PH_ENTER;
      end else if (sw == SW_ON) begin
        mode_q = MODE_ON;
      end else begin
        lamp_q = 1'b0;
      end
    end else begin
      if (sw == SW_OFF) begin
        mode_q = MODE_OFF;
      end else if (sw == SW_AUTO) begin
        mode_q  = MODE_AUTO;
        phase_q = PH_ENTER;
      end else begin
        lamp_q = 1'b1;
      end
    end
    r.headlight = lamp_q;
    r.mode      = mode_q;
    r.phase     = phase_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      cfg_q.on_thr   = OnThrRst;
      cfg_q.off_thr  = OffThrRst;
      cfg_q.off_dly  = OffDlyRst;
      cfg_q.on_dly   = OnDlyRst;
      cfg_q.dark_lit = DarkLitRst;
      started_q      = 1'b0;
      mode_q         = MODE_OFF;
      phase_q        = PH_NONE;
      hold_q         = '0;
      lamp_q         = 1'b0;
      lamp_results_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[ResW-1:0]);
        if (lamp_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fails++;
        end else begin
          want = lamp_results_q.pop_front();
          if (got.headlight !== want.headlight) begin
            $display("%0t: headlight expected %0d actual %0d",
                     $time, want.headlight, got.headlight);
            fails++;
          end
          if (got.mode !== want.mode) begin
            $display("%0t: mode expected %0d actual %0d", $time, want.mode, got.mode);
            fails++;
          end
          if (got.phase !== want.phase) begin
            $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        lamp_results_q.push_back(advance_tick(switch_e'(s_axis_tdata[1:0]),
                                              s_axis_tdata[LuxW+1:2]));
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_ON_THR:   cfg_q.on_thr   = cfg_wdata_i;
          CFG_OFF_THR:  cfg_q.off_thr  = cfg_wdata_i;
          CFG_OFF_DLY:  cfg_q.off_dly  = cfg_wdata_i;
          CFG_ON_DLY:   cfg_q.on_dly   = cfg_wdata_i;
          CFG_DARK_LIT: cfg_q.dark_lit = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o    <= lamp_results_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: dv/tb_auto_headlight_mode_controller.sv
// Testbench top for the headlight mode controller: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_auto_headlight_mode_controller;
  import ahmc_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_we_i;
  logic [CfgAddrW-1:0]  cfg_addr_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  int                   fail_count;
  int                   pending;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   hold_requests = 0;
  int                   holds_served = 0;
  cfg_t                 cur;

  auto_headlight_mode_controller dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  ahmc_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side; a requested long hold backs the block up into its input
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_tick(input switch_e sw, input logic [LuxW-1:0] lux);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-LuxW-2){1'b0}}, lux, sw};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    cur = c;
    write_reg(CFG_ON_THR, c.on_thr);
    write_reg(CFG_OFF_THR, c.off_thr);
    write_reg(CFG_OFF_DLY, c.off_dly);
    write_reg(CFG_ON_DLY, c.on_dly);
    write_reg(CFG_DARK_LIT, {{(CfgDataW-1){1'b0}}, c.dark_lit});
    cfg_we_i <= 1'b0;
  endtask

  // level: 0 dark, 1 bright, 2 near a threshold, 3 anything
  function automatic logic [LuxW-1:0] pick_lux(input int level);
    logic [LuxW-1:0] lux;
    case (level)
      0: begin
        if (cur.on_thr == 0) lux = '0;
        else if ($urandom_range(3) == 0) lux = cur.on_thr - 1'b1;
        else lux = LuxW'($urandom_range(cur.on_thr - 1, 0));
      end
      1: begin
        if (cur.off_thr == '1) lux = '1;
        else if ($urandom_range(3) == 0) lux = cur.off_thr + 1'b1;
        else lux = LuxW'($urandom_range(16'hFFFF, cur.off_thr + 1));
      end
      2: begin
        case ($urandom_range(3))
          0: lux = cur.on_thr;
          1: lux = cur.off_thr;
          2: lux = cur.on_thr - 1'b1;
          default: lux = cur.off_thr + 1'b1;
        endcase
      end
      default: lux = LuxW'($urandom_range(16'hFFFF, 0));
    endcase
    return lux;
  endfunction

  // mostly auto ticks in runs of steady light, now and then a switch change
  task automatic random_ticks(input int count);
    int      sent;
    int      level;
    int      run_len;
    int      pick;
    switch_e sw;
    sent = 0;
    while (sent < count) begin
      pick    = $urandom_range(9);
      level   = (pick < 4) ? 0 : (pick < 8) ? 1 : (pick == 8) ? 2 : 3;
      run_len = $urandom_range(12, 1);
      for (int k = 0; k < run_len && sent < count; k++) begin
        if ($urandom_range(19) == 0) sw = switch_e'($urandom_range(3));
        else sw = ($urandom_range(3) == 0) ? SW_ANY : SW_AUTO;
        send_tick(sw, pick_lux(level));
        sent++;
      end
    end
  endtask

  initial begin
    int   idle_tbl[6]  = '{0, 49, 0, 30, 30, 0};
    int   stall_tbl[6] = '{0, 0, 49, 30, 30, 0};
    int   count_tbl[6] = '{180, 160, 160, 160, 70, 50};
    cfg_t c;
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CFG_ON_THR;
    cfg_wdata_i   <= '0;
    cur = '{on_thr: OnThrRst, off_thr: OffThrRst, off_dly: OffDlyRst,
            on_dly: OnDlyRst, dark_lit: DarkLitRst};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // manual modes under reset settings
    send_tick(SW_OFF, 16'd0);
    send_tick(SW_ANY, 16'hFFFF);
    send_tick(SW_ON, 16'd0);
    send_tick(SW_ANY, 16'd0);
    send_tick(SW_OFF, 16'd0);
    send_tick(SW_ON, 16'hFFFF);
    wait_idle();
    apply_settings('{on_thr: 16'd60, off_thr: 16'd70, off_dly: 16'd2, on_dly: 16'd1,
                     dark_lit: 1'b1});
    // auto phases, threshold edges and hold delays
    send_tick(SW_AUTO, 16'd0);
    send_tick(SW_AUTO, 16'd0);
    send_tick(SW_AUTO, 16'd70);
    send_tick(SW_AUTO, 16'd71);
    send_tick(SW_AUTO, 16'd71);
    send_tick(SW_ANY, 16'hFFFF);
    send_tick(SW_AUTO, 16'd71);
    send_tick(SW_AUTO, 16'd60);
    send_tick(SW_AUTO, 16'd59);
    send_tick(SW_AUTO, 16'd0);
    send_tick(SW_AUTO, 16'd0);
    send_tick(SW_AUTO, 16'd0);
    send_tick(SW_AUTO, 16'hFFFF);
    send_tick(SW_AUTO, 16'd70);
    send_tick(SW_ON, 16'd0);
    send_tick(SW_AUTO, 16'hFFFF);
    send_tick(SW_AUTO, 16'hFFFF);
    send_tick(SW_AUTO, 16'd0);
    send_tick(SW_AUTO, 16'd60);
    send_tick(SW_OFF, 16'd0);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      if (p == 4) begin
        c = '{on_thr: 16'hFFFF, off_thr: 16'd0, off_dly: 16'd0, on_dly: 16'd0,
              dark_lit: 1'b0};
      end else if (p == 5) begin
        c = '{on_thr: 16'd0, off_thr: 16'hFFFF, off_dly: 16'hFFFF, on_dly: 16'hFFFF,
              dark_lit: 1'b1};
      end else begin
        c.on_thr   = ThrW'($urandom_range(40000, 0));
        c.off_thr  = ThrW'(c.on_thr + $urandom_range(500, 0));
        c.off_dly  = ThrW'($urandom_range(8, 0));
        c.on_dly   = ThrW'($urandom_range(8, 0));
        c.dark_lit = 1'($urandom_range(1, 0));
      end
      apply_settings(c);
      send_idle_pct  = idle_tbl[p];
      recv_stall_pct = stall_tbl[p];
      if (p == 0) hold_requests++;
      random_ticks(count_tbl[p]);
      wait_idle();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < 10000 && pending != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
